// ===== rtl/imi_pkg.sv =====
`timescale 1ns / 1ps
package imi_pkg;

    localparam int MAX_DIMENSION_DEFAULT = 8;
    localparam int DIM_W = 4;
    localparam int DIM_RESET = 8;
    localparam int ELEM_W = 16;
    localparam int WIDE_W = 160;
    localparam int LIMB_W = 32;
    localparam int LIMBS = 5;
    localparam int LIMB_IDX_W = 3;
    localparam int SCALE_W = ELEM_W + 1;
    localparam int CARRY_W = 20;
    localparam int OUT_W = 64;
    localparam int POS_W = 3;
    localparam int FRAC_W = 16;
    localparam int DIV_CNT_W = 8;

    typedef struct packed {
        logic                  load_we;
        logic                  elem_rd;
        logic                  mem_init;
        logic                  mem_wr;
        logic                  mem_rd;
        logic                  acc_clear;
        logic                  s_load;
        logic                  s_neg;
        logic                  mac_en;
        logic [LIMB_IDX_W-1:0] limb;
        logic                  det_latch;
        logic                  cof_wr;
        logic                  cof_neg;
        logic                  cof_rd;
        logic                  prep;
        logic                  div_start;
        logic                  emit;
        logic                  emit_sing;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic div_done;
    } sts_t;

    function automatic logic fits64(input logic [WIDE_W-1:0] x);
        fits64 = (x[WIDE_W-1:OUT_W-1] == '0) || (x[WIDE_W-1:OUT_W-1] == '1);
    endfunction

endpackage

// ===== rtl/imi_divider.sv =====
`timescale 1ns / 1ps
module imi_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [imi_pkg::WIDE_W-1:0] dividend,
    input  logic [imi_pkg::WIDE_W-1:0] divisor,
    output logic                       done,
    output logic [imi_pkg::WIDE_W-1:0] quotient
);
    import imi_pkg::*;

    logic [WIDE_W-1:0]    num_reg, num_next;
    logic [WIDE_W-1:0]    quo_reg, quo_next;
    logic [WIDE_W:0]      rem_reg, rem_next, rem_sh;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg[WIDE_W-1:0], num_reg[WIDE_W-1]};
        ge        = rem_sh >= {1'b0, divisor};
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(WIDE_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
            quo_next = {quo_reg[WIDE_W-2:0], ge};
            num_next = {num_reg[WIDE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/imi_datapath.sv =====
`timescale 1ns / 1ps
module imi_datapath #(
    parameter  int MAX_DIMENSION = imi_pkg::MAX_DIMENSION_DEFAULT,
    localparam int SA_W = (MAX_DIMENSION * MAX_DIMENSION > 1) ?
                          $clog2(MAX_DIMENSION * MAX_DIMENSION) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  imi_pkg::cmd_t                     cmd,
    output imi_pkg::sts_t                     sts,
    input  logic [SA_W-1:0]                   store_addr,
    input  logic [SA_W-1:0]                   cof_addr,
    input  logic [MAX_DIMENSION-1:0]          mem_addr,
    input  logic [imi_pkg::POS_W-1:0]         pos_row,
    input  logic [imi_pkg::POS_W-1:0]         pos_col,
    input  logic signed [imi_pkg::ELEM_W-1:0] element_value,
    output logic                              valid,
    output logic [imi_pkg::POS_W-1:0]         row_index,
    output logic [imi_pkg::POS_W-1:0]         column_index,
    output logic signed [imi_pkg::OUT_W-1:0]  adjugate_entry,
    output logic signed [imi_pkg::OUT_W-1:0]  determinant_value,
    output logic signed [imi_pkg::OUT_W-1:0]  inverse_entry,
    output logic                              singular_flag,
    output logic                              overflow_flag,
    output logic                              last_result
);
    import imi_pkg::*;

    localparam int STORE_DEPTH = MAX_DIMENSION * MAX_DIMENSION;
    localparam int MINOR_DEPTH = 2 ** MAX_DIMENSION;

    logic [ELEM_W-1:0] store_mem [STORE_DEPTH];
    logic [WIDE_W-1:0] minor_mem [MINOR_DEPTH];
    logic [WIDE_W-1:0] cof_mem [STORE_DEPTH];

    logic [ELEM_W-1:0]                 elem_rd_reg;
    logic [WIDE_W-1:0]                 minor_rd_reg;
    logic [WIDE_W-1:0]                 cof_rd_reg;
    logic [WIDE_W-1:0]                 acc_reg;
    logic signed [CARRY_W-1:0]         carry_reg;
    logic signed [SCALE_W-1:0]         s_reg;
    logic [WIDE_W-1:0]                 det_reg;
    logic [WIDE_W-1:0]                 adj_reg;
    logic [WIDE_W-1:0]                 num_mag_reg;
    logic [WIDE_W-1:0]                 den_mag_reg;
    logic                              neg_reg;
    logic                              valid_reg;

    logic signed [SCALE_W-1:0]         elem_ext;
    logic [LIMB_W-1:0]                 x_limb;
    logic [LIMB_W-1:0]                 acc_limb;
    logic signed [CARRY_W-1:0]         carry_in;
    logic signed [LIMB_W+SCALE_W:0]    prod;
    logic signed [LIMB_W+CARRY_W-1:0]  sum;
    logic [WIDE_W-1:0]                 num_shift;
    logic [WIDE_W-1:0]                 quo;
    logic [WIDE_W-1:0]                 quo_signed;
    logic                              div_done;

    // limb-serial multiply-accumulate
    always_comb
    begin
        elem_ext   = {elem_rd_reg[ELEM_W-1], elem_rd_reg};
        x_limb     = minor_rd_reg[cmd.limb*LIMB_W +: LIMB_W];
        acc_limb   = acc_reg[cmd.limb*LIMB_W +: LIMB_W];
        carry_in   = (cmd.limb == '0) ? '0 : carry_reg;
        prod       = $signed({1'b0, x_limb}) * s_reg;
        sum        = prod + carry_in + $signed({1'b0, acc_limb});
        num_shift  = {cof_rd_reg[WIDE_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        quo_signed = neg_reg ? (~quo + 1'b1) : quo;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            store_mem[store_addr] <= element_value;
        if (cmd.elem_rd)
            elem_rd_reg <= store_mem[store_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_init || cmd.mem_wr)
            minor_mem[mem_addr] <= cmd.mem_init ? WIDE_W'(1) : acc_reg;
        if (cmd.mem_rd)
            minor_rd_reg <= minor_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cof_wr)
            cof_mem[cof_addr] <= cmd.cof_neg ? (~minor_rd_reg + 1'b1) : minor_rd_reg;
        if (cmd.cof_rd)
            cof_rd_reg <= cof_mem[cof_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.mac_en)
        begin
            acc_reg[cmd.limb*LIMB_W +: LIMB_W] <= sum[LIMB_W-1:0];
            carry_reg <= sum[LIMB_W +: CARRY_W];
        end
        if (cmd.s_load)
            s_reg <= cmd.s_neg ? -elem_ext : elem_ext;
        if (cmd.det_latch)
        begin
            det_reg     <= minor_rd_reg;
            den_mag_reg <= minor_rd_reg[WIDE_W-1] ? (~minor_rd_reg + 1'b1) : minor_rd_reg;
        end
        if (cmd.prep)
        begin
            adj_reg     <= cof_rd_reg;
            neg_reg     <= num_shift[WIDE_W-1] ^ det_reg[WIDE_W-1];
            num_mag_reg <= num_shift[WIDE_W-1] ? (~num_shift + 1'b1) : num_shift;
        end
    end

    imi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_mag_reg),
        .divisor  (den_mag_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.emit_sing)
        begin
            row_index         <= '0;
            column_index      <= '0;
            adjugate_entry    <= '0;
            determinant_value <= '0;
            inverse_entry     <= '0;
            singular_flag     <= 1'b1;
            overflow_flag     <= 1'b0;
            last_result       <= 1'b1;
        end
        else if (cmd.emit)
        begin
            row_index         <= pos_row;
            column_index      <= pos_col;
            adjugate_entry    <= adj_reg[OUT_W-1:0];
            determinant_value <= det_reg[OUT_W-1:0];
            inverse_entry     <= quo_signed[OUT_W-1:0];
            singular_flag     <= 1'b0;
            overflow_flag     <= !fits64(det_reg) || !fits64(adj_reg) || !fits64(quo_signed);
            last_result       <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit || cmd.emit_sing;
    end

    assign valid        = valid_reg;
    assign sts.det_zero = (det_reg == '0);
    assign sts.div_done = div_done;

endmodule

// ===== rtl/imi_ctrl.sv =====
`timescale 1ns / 1ps
module imi_ctrl #(
    parameter  int MAX_DIMENSION = imi_pkg::MAX_DIMENSION_DEFAULT,
    localparam int SA_W = (MAX_DIMENSION * MAX_DIMENSION > 1) ?
                          $clog2(MAX_DIMENSION * MAX_DIMENSION) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             config_write,
    input  logic [imi_pkg::DIM_W-1:0]        config_data,
    output logic                             busy,
    input  imi_pkg::sts_t                    sts,
    output imi_pkg::cmd_t                    cmd,
    output logic [SA_W-1:0]                  store_addr,
    output logic [SA_W-1:0]                  cof_addr,
    output logic [MAX_DIMENSION-1:0]         mem_addr,
    output logic [imi_pkg::POS_W-1:0]        pos_row,
    output logic [imi_pkg::POS_W-1:0]        pos_col
);
    import imi_pkg::*;

    localparam int NW    = $clog2(MAX_DIMENSION + 1);
    localparam int MW1   = MAX_DIMENSION + 1;
    localparam int CNT_W = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_PASS_INIT, S_MASK, S_COL, S_WAIT, S_MAC, S_WRITE, S_PASS_END,
        S_DET_LATCH, S_DET_CHECK, S_SING, S_CJ_READ, S_CJ_WRITE, S_OUT_READ,
        S_OUT_PREP, S_DIV_START, S_DIV_WAIT, S_EMIT
    } state_t;

    state_t                state_reg;
    logic                  busy_reg;
    logic [DIM_W-1:0]      dim_reg;
    logic [CNT_W-1:0]      load_cnt_reg;
    logic [NW-1:0]         pass_reg;
    logic [NW-1:0]         m_reg;
    logic [MW1-1:0]        mask_reg;
    logic [NW-1:0]         col_reg;
    logic                  par_reg;
    logic [LIMB_IDX_W-1:0] limb_reg;
    logic [NW-1:0]         row_reg;
    logic [NW-1:0]         r_reg;
    logic [NW-1:0]         c_reg;

    logic [NW-1:0]         n_eff;
    logic [CNT_W-1:0]      nn;
    logic [MW1-1:0]        mask_end;
    logic [MW1-1:0]        full_mask;
    logic [MW1-1:0]        col_bit;
    logic [MW1-1:0]        term_mask;
    logic [MW1-1:0]        cof_mask;
    logic [NW-1:0]         k_cnt;
    logic [NW-1:0]         idx;
    logic                  out_last;

    function automatic logic [NW-1:0] popcount(input logic [MAX_DIMENSION-1:0] v);
        logic [NW-1:0] k;
        k = '0;
        for (int b = 0; b < MAX_DIMENSION; b++)
            k = k + NW'(v[b]);
        return k;
    endfunction

    always_comb
    begin
        if (dim_reg == '0)
            n_eff = NW'(1);
        else if (32'(dim_reg) > MAX_DIMENSION)
            n_eff = NW'(MAX_DIMENSION);
        else
            n_eff = NW'(dim_reg);
        nn        = CNT_W'(n_eff) * CNT_W'(n_eff);
        mask_end  = MW1'(1) << n_eff;
        full_mask = mask_end - 1'b1;
        col_bit   = MW1'(1) << col_reg;
        term_mask = mask_reg ^ col_bit;
        cof_mask  = full_mask & ~col_bit;
        k_cnt     = popcount(mask_reg[MAX_DIMENSION-1:0]);
        idx       = m_reg - k_cnt;
        out_last  = (r_reg == n_eff - 1'b1) && (c_reg == n_eff - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_reg     <= 1'b0;
            dim_reg      <= DIM_W'(DIM_RESET);
            load_cnt_reg <= '0;
            pass_reg     <= '0;
            m_reg        <= '0;
            mask_reg     <= '0;
            col_reg      <= '0;
            par_reg      <= 1'b0;
            limb_reg     <= '0;
            row_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (load_cnt_reg == nn - 1'b1)
                        begin
                            load_cnt_reg <= '0;
                            pass_reg     <= '0;
                            busy_reg     <= 1'b1;
                            state_reg    <= S_PASS_INIT;
                        end
                        else
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                    end
                end
                S_PASS_INIT:
                begin
                    mask_reg  <= MW1'(1);
                    m_reg     <= (pass_reg == '0) ? n_eff : (n_eff - 1'b1);
                    state_reg <= S_MASK;
                end
                S_MASK:
                begin
                    if (mask_reg == mask_end)
                    begin
                        col_reg   <= '0;
                        state_reg <= S_PASS_END;
                    end
                    else if (k_cnt > m_reg)
                        mask_reg <= mask_reg + 1'b1;
                    else
                    begin
                        if (pass_reg == '0 || idx + 1'b1 < pass_reg)
                            row_reg <= idx;
                        else
                            row_reg <= idx + 1'b1;
                        col_reg   <= '0;
                        par_reg   <= 1'b0;
                        state_reg <= S_COL;
                    end
                end
                S_COL:
                begin
                    if (col_reg == n_eff)
                        state_reg <= S_WRITE;
                    else if (mask_reg[col_reg])
                        state_reg <= S_WAIT;
                    else
                        col_reg <= col_reg + 1'b1;
                end
                S_WAIT:
                begin
                    limb_reg  <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (limb_reg == LIMB_IDX_W'(LIMBS - 1))
                    begin
                        col_reg   <= col_reg + 1'b1;
                        par_reg   <= !par_reg;
                        state_reg <= S_COL;
                    end
                    else
                        limb_reg <= limb_reg + 1'b1;
                end
                S_WRITE:
                begin
                    mask_reg  <= mask_reg + 1'b1;
                    state_reg <= S_MASK;
                end
                S_PASS_END:
                begin
                    if (pass_reg == '0)
                        state_reg <= S_DET_LATCH;
                    else
                        state_reg <= S_CJ_READ;
                end
                S_DET_LATCH:
                    state_reg <= S_DET_CHECK;
                S_DET_CHECK:
                begin
                    if (sts.det_zero)
                        state_reg <= S_SING;
                    else
                    begin
                        pass_reg  <= NW'(1);
                        state_reg <= S_PASS_INIT;
                    end
                end
                S_SING:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_CJ_READ:
                begin
                    if (col_reg == n_eff)
                    begin
                        if (pass_reg == n_eff)
                        begin
                            r_reg     <= '0;
                            c_reg     <= '0;
                            state_reg <= S_OUT_READ;
                        end
                        else
                        begin
                            pass_reg  <= pass_reg + 1'b1;
                            state_reg <= S_PASS_INIT;
                        end
                    end
                    else
                        state_reg <= S_CJ_WRITE;
                end
                S_CJ_WRITE:
                begin
                    col_reg   <= col_reg + 1'b1;
                    state_reg <= S_CJ_READ;
                end
                S_OUT_READ:
                    state_reg <= S_OUT_PREP;
                S_OUT_PREP:
                    state_reg <= S_DIV_START;
                S_DIV_START:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (sts.div_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_last)
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (c_reg == n_eff - 1'b1)
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + 1'b1;
                        end
                        else
                            c_reg <= c_reg + 1'b1;
                        state_reg <= S_OUT_READ;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            if (config_write)
            begin
                dim_reg      <= config_data;
                load_cnt_reg <= '0;
            end
        end
    end

    // command decode
    always_comb
    begin
        cmd        = '0;
        cmd.limb   = limb_reg;
        cmd.s_neg  = par_reg;
        cmd.last   = out_last;
        store_addr = SA_W'(row_reg) * SA_W'(n_eff) + SA_W'(col_reg);
        cof_addr   = SA_W'(c_reg * MAX_DIMENSION + r_reg);
        mem_addr   = mask_reg[MAX_DIMENSION-1:0];
        case (state_reg)
            S_IDLE:
            begin
                store_addr  = SA_W'(load_cnt_reg);
                cmd.load_we = start;
            end
            S_PASS_INIT:
            begin
                mem_addr     = '0;
                cmd.mem_init = 1'b1;
            end
            S_MASK:
                cmd.acc_clear = (mask_reg != mask_end) && (k_cnt <= m_reg);
            S_COL:
            begin
                mem_addr    = term_mask[MAX_DIMENSION-1:0];
                cmd.mem_rd  = (col_reg != n_eff) && mask_reg[col_reg];
                cmd.elem_rd = cmd.mem_rd;
            end
            S_WAIT:
                cmd.s_load = 1'b1;
            S_MAC:
                cmd.mac_en = 1'b1;
            S_WRITE:
                cmd.mem_wr = 1'b1;
            S_PASS_END:
            begin
                mem_addr   = full_mask[MAX_DIMENSION-1:0];
                cmd.mem_rd = (pass_reg == '0);
            end
            S_DET_LATCH:
                cmd.det_latch = 1'b1;
            S_SING:
                cmd.emit_sing = 1'b1;
            S_CJ_READ:
            begin
                mem_addr   = cof_mask[MAX_DIMENSION-1:0];
                cmd.mem_rd = (col_reg != n_eff);
            end
            S_CJ_WRITE:
            begin
                cof_addr    = SA_W'((pass_reg - 1'b1) * MAX_DIMENSION + col_reg);
                cmd.cof_wr  = 1'b1;
                cmd.cof_neg = !(pass_reg[0] ^ col_reg[0]);
            end
            S_OUT_READ:
                cmd.cof_rd = 1'b1;
            S_OUT_PREP:
                cmd.prep = 1'b1;
            S_DIV_START:
                cmd.div_start = 1'b1;
            S_EMIT:
                cmd.emit = 1'b1;
            default:
                cmd.load_we = 1'b0;
        endcase
    end

    assign busy    = busy_reg;
    assign pos_row = POS_W'(r_reg);
    assign pos_col = POS_W'(c_reg);

endmodule

// ===== rtl/integer_matrix_inverse_top.sv =====
`timescale 1ns / 1ps
// integer matrix inverse by adjugate and determinant
// config: config_write with config_data sets the matrix order n (0 acts as 1,
//   values above MAX_DIMENSION act as MAX_DIMENSION) and restarts loading
// input: one element word per cycle, row-major, taken when start is high and
//   busy is low
// after the last word busy rises and the block computes the determinant and
//   every cofactor exactly in 160 bits with a limb-serial multiply-accumulate
//   over a table of minors; each of the n+1 passes steps through the 2^n - 1
//   nonzero column masks and skips those with too many set bits
// output: valid is high for exactly one cycle per result word; a singular
//   matrix gives one word with singular_flag set, otherwise n*n words in
//   row-major order; each inverse entry comes from the bit-serial divider
// last_result marks the final word; busy falls in the same cycle it appears
// the receiver cannot stall the block and takes every word as it comes
// reset clears the control state and sets the order to 8; no load is pending
module integer_matrix_inverse_top #(
    parameter int MAX_DIMENSION = imi_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              config_write,
    input  logic [imi_pkg::DIM_W-1:0]         config_data,
    input  logic signed [imi_pkg::ELEM_W-1:0] element_value,
    output logic                              valid,
    output logic [imi_pkg::POS_W-1:0]         row_index,
    output logic [imi_pkg::POS_W-1:0]         column_index,
    output logic signed [imi_pkg::OUT_W-1:0]  adjugate_entry,
    output logic signed [imi_pkg::OUT_W-1:0]  determinant_value,
    output logic signed [imi_pkg::OUT_W-1:0]  inverse_entry,
    output logic                              singular_flag,
    output logic                              overflow_flag,
    output logic                              last_result
);
    import imi_pkg::*;

    localparam int SA_W = (MAX_DIMENSION * MAX_DIMENSION > 1) ?
                          $clog2(MAX_DIMENSION * MAX_DIMENSION) : 1;

    cmd_t                     cmd;
    sts_t                     sts;
    logic [SA_W-1:0]          store_addr;
    logic [SA_W-1:0]          cof_addr;
    logic [MAX_DIMENSION-1:0] mem_addr;
    logic [POS_W-1:0]         pos_row;
    logic [POS_W-1:0]         pos_col;

    imi_ctrl #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .config_write (config_write),
        .config_data  (config_data),
        .busy         (busy),
        .sts          (sts),
        .cmd          (cmd),
        .store_addr   (store_addr),
        .cof_addr     (cof_addr),
        .mem_addr     (mem_addr),
        .pos_row      (pos_row),
        .pos_col      (pos_col)
    );

    imi_datapath #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .store_addr        (store_addr),
        .cof_addr          (cof_addr),
        .mem_addr          (mem_addr),
        .pos_row           (pos_row),
        .pos_col           (pos_col),
        .element_value     (element_value),
        .valid             (valid),
        .row_index         (row_index),
        .column_index      (column_index),
        .adjugate_entry    (adjugate_entry),
        .determinant_value (determinant_value),
        .inverse_entry     (inverse_entry),
        .singular_flag     (singular_flag),
        .overflow_flag     (overflow_flag),
        .last_result       (last_result)
    );

    a_word_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result word without a preceding busy cycle");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_result |-> busy)
        else $error("busy dropped before the last word");

    a_singular_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && singular_flag |-> last_result)
        else $error("singular word not marked last");

    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_result |=> !valid)
        else $error("word after the last word");

endmodule
